// ----- hw/rtl/e2q_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_pkg
// Types, constants and fixed-point helpers for the Euler to quaternion unit.
// ----------------------------------------------------------------------------
package e2q_pkg;

    typedef struct packed {
        logic signed [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
    } e2q_in_t;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } e2q_out_t;

    typedef logic signed [21:0] e2q_trig_t;
    typedef logic [10:1][29:0] e2q_pow_t;

    localparam int FULL_TURN = 46080;
    localparam int QUARTER   = 11520;
    localparam int EIGHTH    = 5760;
    localparam int HALF_DEN  = 2 * QUARTER;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam longint PI_Q30  = 64'd3373259426;
    localparam longint ONE_Q30 = 64'd1073741824;

    // t = off*TQ_A + (off*TQ_B + QUARTER) / HALF_DEN
    localparam longint TQ_A     = PI_Q30 / HALF_DEN;
    localparam longint TQ_B     = PI_Q30 % HALF_DEN;
    localparam int     DEN_SH   = 9;
    localparam int     DEN_ODD  = HALF_DEN >> DEN_SH;
    localparam int     REC_SH   = 24;
    localparam longint REC_ODD  = ((64'd1 << REC_SH) + DEN_ODD - 1) / DEN_ODD;

    localparam int SH2  = 32;
    localparam int SH3  = 34;
    localparam int SH4  = 36;
    localparam int SH5  = 38;
    localparam int SH6  = 41;
    localparam int SH7  = 44;
    localparam int SH8  = 47;
    localparam int SH9  = 50;
    localparam int SH10 = 53;

    localparam longint F2  = 2;
    localparam longint F3  = 6;
    localparam longint F4  = 24;
    localparam longint F5  = 120;
    localparam longint F6  = 720;
    localparam longint F7  = 5040;
    localparam longint F8  = 40320;
    localparam longint F9  = 362880;
    localparam longint F10 = 3628800;

    localparam longint K2  = ((64'd1 << SH2)  + F2  - 1) / F2;
    localparam longint K3  = ((64'd1 << SH3)  + F3  - 1) / F3;
    localparam longint K4  = ((64'd1 << SH4)  + F4  - 1) / F4;
    localparam longint K5  = ((64'd1 << SH5)  + F5  - 1) / F5;
    localparam longint K6  = ((64'd1 << SH6)  + F6  - 1) / F6;
    localparam longint K7  = ((64'd1 << SH7)  + F7  - 1) / F7;
    localparam longint K8  = ((64'd1 << SH8)  + F8  - 1) / F8;
    localparam longint K9  = ((64'd1 << SH9)  + F9  - 1) / F9;
    localparam longint K10 = ((64'd1 << SH10) + F10 - 1) / F10;

    localparam int SC_LATENCY  = 12;
    localparam int CMB_LATENCY = 5;
    localparam int E2Q_LATENCY = SC_LATENCY + CMB_LATENCY;

    function automatic logic [29:0] fx_mul(input logic [29:0] a, input logic [29:0] b);
        logic [59:0] p;
        p = 60'(a) * 60'(b) + (60'(1) << 29);
        return p[59:30];
    endfunction

    // round-half-up quotient by reciprocal multiply
    function automatic logic [29:0] fx_rdiv(input logic [29:0] p, input longint d,
                                            input longint k, input int sh);
        logic [30:0] x;
        logic [63:0] prod;
        x    = 31'(p) + 31'(d >> 1);
        prod = 64'(x) * 64'(33'(k));
        return 30'(prod >> sh);
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/euler_to_quaternion_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euler_to_quaternion_unit
// Z-Y-X Euler angles (1/64 degree) to a saturated Q2.14 unit quaternion.
//
//   channel  direction  handshake                  payload
//   angle    in         angle_valid / angle_ready  e2q_in_t
//   quat     out        quat_valid / quat_ready    e2q_out_t
//
// One transaction per cycle while the output is not stalled; the
// sine/cosine pipeline feeds the product and rounding pipeline.
// The whole pipeline advances together; a stalled output holds every stage.
// Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module euler_to_quaternion_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              angle_valid,
    output logic              angle_ready,
    input  e2q_pkg::e2q_in_t  angle,
    output logic              quat_valid,
    input  logic              quat_ready,
    output e2q_pkg::e2q_out_t quat
);
    import e2q_pkg::*;

    logic                   en;
    logic [E2Q_LATENCY-1:0] vld_reg, vld_next;
    e2q_trig_t              sy, cy, sp, cp, sr, cr;

    assign en          = !vld_reg[E2Q_LATENCY-1] || quat_ready;
    assign angle_ready = en;
    assign quat_valid  = vld_reg[E2Q_LATENCY-1];
    assign vld_next    = {vld_reg[E2Q_LATENCY-2:0], angle_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    e2q_sincos u_yaw (
        .clk     (clk),
        .en      (en),
        .angle   (angle.yaw_angle),
        .sin_val (sy),
        .cos_val (cy)
    );

    e2q_sincos u_pitch (
        .clk     (clk),
        .en      (en),
        .angle   (angle.pitch_angle),
        .sin_val (sp),
        .cos_val (cp)
    );

    e2q_sincos u_roll (
        .clk     (clk),
        .en      (en),
        .angle   (angle.roll_angle),
        .sin_val (sr),
        .cos_val (cr)
    );

    e2q_combine u_combine (
        .clk  (clk),
        .en   (en),
        .sy   (sy),
        .cy   (cy),
        .sp   (sp),
        .cp   (cp),
        .sr   (sr),
        .cr   (cr),
        .quat (quat)
    );

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && !quat_ready |=> quat_valid)
        else $error("result dropped while stalled");

    a_ready_only_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !angle_ready |-> quat_valid)
        else $error("input blocked with empty output");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid |-> (quat.quat_x <= 16'sd16384 && quat.quat_x >= -16'sd16384
                     && quat.quat_y <= 16'sd16384 && quat.quat_y >= -16'sd16384
                     && quat.quat_z <= 16'sd16384 && quat.quat_z >= -16'sd16384
                     && quat.quat_w <= 16'sd16384 && quat.quat_w >= -16'sd16384))
        else $error("component outside saturation range");

endmodule
`default_nettype wire

// ----- hw/rtl/e2q_sincos.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_sincos
// Twelve-stage pipeline: sine and cosine in Q20 of a half angle.
// ----------------------------------------------------------------------------
module e2q_sincos (
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] angle,
    output e2q_pkg::e2q_trig_t sin_val,
    output e2q_pkg::e2q_trig_t cos_val
);
    import e2q_pkg::*;

    logic [16:0] rr_ext;
    logic [15:0] rr;
    logic [13:0] off_w;
    logic [1:0]  quad_w;
    logic        mir_w;
    logic [2:0]  side_next;
    logic [12:0] off1_next;
    logic [36:0] rec_prod;

    logic [2:0]  side_reg [1:11];
    logic [12:0] off1_reg;
    logic [29:0] oa2_reg, oa3_reg;
    logic [26:0] ob2_reg;
    logic [12:0] qt3_reg;
    logic [29:0] t4_reg;
    e2q_pow_t    p5_next, p6_next, p7_next, p8_next, p9_next, d10_next;
    e2q_pow_t    p5_reg, p6_reg, p7_reg, p8_reg, p9_reg, d10_reg;
    logic signed [32:0] s11_next, c11_next, s11_reg, c11_reg;
    logic [30:0] s_cl, c_cl;
    logic [20:0] s_q, c_q, s_m, c_m;
    logic signed [21:0] s_pos, c_pos;
    e2q_trig_t   sin_next, cos_next, sin_reg, cos_reg;

    always_comb
    begin
        rr_ext = angle[15] ? (17'(angle) + 17'(FULL_TURN)) : {1'b0, angle};
        rr     = rr_ext[15:0];
        if (rr < 16'(QUARTER))
        begin
            quad_w = QUAD_0;
            off_w  = 14'(rr);
        end
        else if (rr < 16'(2 * QUARTER))
        begin
            quad_w = QUAD_1;
            off_w  = 14'(rr - 16'(QUARTER));
        end
        else if (rr < 16'(3 * QUARTER))
        begin
            quad_w = QUAD_2;
            off_w  = 14'(rr - 16'(2 * QUARTER));
        end
        else
        begin
            quad_w = QUAD_3;
            off_w  = 14'(rr - 16'(3 * QUARTER));
        end
        mir_w     = off_w > 14'(EIGHTH);
        off1_next = mir_w ? 13'(14'(QUARTER) - off_w) : off_w[12:0];
        side_next = {quad_w, mir_w};
    end

    assign rec_prod = 37'(ob2_reg >> DEN_SH) * 37'(REC_ODD);

    always_comb
    begin
        p5_next    = '0;
        p5_next[1] = t4_reg;
        p5_next[2] = fx_mul(t4_reg, t4_reg);

        p6_next    = p5_reg;
        p6_next[3] = fx_mul(p5_reg[2], p5_reg[1]);
        p6_next[4] = fx_mul(p5_reg[2], p5_reg[2]);

        p7_next    = p6_reg;
        p7_next[5] = fx_mul(p6_reg[3], p6_reg[2]);
        p7_next[6] = fx_mul(p6_reg[4], p6_reg[2]);

        p8_next    = p7_reg;
        p8_next[7] = fx_mul(p7_reg[5], p7_reg[2]);
        p8_next[8] = fx_mul(p7_reg[6], p7_reg[2]);

        p9_next     = p8_reg;
        p9_next[9]  = fx_mul(p8_reg[7], p8_reg[2]);
        p9_next[10] = fx_mul(p8_reg[8], p8_reg[2]);

        d10_next[1]  = p9_reg[1];
        d10_next[2]  = fx_rdiv(p9_reg[2],  F2,  K2,  SH2);
        d10_next[3]  = fx_rdiv(p9_reg[3],  F3,  K3,  SH3);
        d10_next[4]  = fx_rdiv(p9_reg[4],  F4,  K4,  SH4);
        d10_next[5]  = fx_rdiv(p9_reg[5],  F5,  K5,  SH5);
        d10_next[6]  = fx_rdiv(p9_reg[6],  F6,  K6,  SH6);
        d10_next[7]  = fx_rdiv(p9_reg[7],  F7,  K7,  SH7);
        d10_next[8]  = fx_rdiv(p9_reg[8],  F8,  K8,  SH8);
        d10_next[9]  = fx_rdiv(p9_reg[9],  F9,  K9,  SH9);
        d10_next[10] = fx_rdiv(p9_reg[10], F10, K10, SH10);

        s11_next = $signed(33'(d10_reg[1])) - $signed(33'(d10_reg[3]))
                 + $signed(33'(d10_reg[5])) - $signed(33'(d10_reg[7]))
                 + $signed(33'(d10_reg[9]));
        c11_next = $signed(33'(ONE_Q30)) - $signed(33'(d10_reg[2]))
                 + $signed(33'(d10_reg[4])) - $signed(33'(d10_reg[6]))
                 + $signed(33'(d10_reg[8])) - $signed(33'(d10_reg[10]));
    end

    always_comb
    begin
        if (s11_reg < 0)
            s_cl = '0;
        else if (s11_reg > $signed(33'(ONE_Q30)))
            s_cl = 31'(ONE_Q30);
        else
            s_cl = s11_reg[30:0];
        if (c11_reg < 0)
            c_cl = '0;
        else if (c11_reg > $signed(33'(ONE_Q30)))
            c_cl = 31'(ONE_Q30);
        else
            c_cl = c11_reg[30:0];
        s_q = 21'((s_cl + 31'd512) >> 10);
        c_q = 21'((c_cl + 31'd512) >> 10);
        s_m = side_reg[11][0] ? c_q : s_q;
        c_m = side_reg[11][0] ? s_q : c_q;
        s_pos = $signed({1'b0, s_m});
        c_pos = $signed({1'b0, c_m});
        case (side_reg[11][2:1])
            QUAD_0:
            begin
                sin_next = s_pos;
                cos_next = c_pos;
            end
            QUAD_1:
            begin
                sin_next = c_pos;
                cos_next = -s_pos;
            end
            QUAD_2:
            begin
                sin_next = -s_pos;
                cos_next = -c_pos;
            end
            default:
            begin
                sin_next = -c_pos;
                cos_next = s_pos;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[1] <= side_next;
            for (int i = 2; i <= 11; i++)
                side_reg[i] <= side_reg[i - 1];
            off1_reg <= off1_next;
            oa2_reg  <= 30'(31'(off1_reg) * 31'(TQ_A));
            ob2_reg  <= 27'(27'(off1_reg) * 27'(TQ_B) + 27'(QUARTER));
            oa3_reg  <= oa2_reg;
            qt3_reg  <= rec_prod[36:REC_SH];
            t4_reg   <= oa3_reg + 30'(qt3_reg);
            p5_reg   <= p5_next;
            p6_reg   <= p6_next;
            p7_reg   <= p7_next;
            p8_reg   <= p8_next;
            p9_reg   <= p9_next;
            d10_reg  <= d10_next;
            s11_reg  <= s11_next;
            c11_reg  <= c11_next;
            sin_reg  <= sin_next;
            cos_reg  <= cos_next;
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/e2q_combine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_combine
// Five-stage pipeline: triple products, sums and Q14 rounding with saturation.
// ----------------------------------------------------------------------------
module e2q_combine (
    input  logic                clk,
    input  logic                en,
    input  e2q_pkg::e2q_trig_t  sy,
    input  e2q_pkg::e2q_trig_t  cy,
    input  e2q_pkg::e2q_trig_t  sp,
    input  e2q_pkg::e2q_trig_t  cp,
    input  e2q_pkg::e2q_trig_t  sr,
    input  e2q_pkg::e2q_trig_t  cr,
    output e2q_pkg::e2q_out_t   quat
);
    import e2q_pkg::*;

    function automatic logic signed [15:0] to_q14(input logic signed [63:0] v);
        logic [63:0] m;
        logic [17:0] r;
        m = v[63] ? 64'(-v) : 64'(v);
        r = 18'((m + (64'd1 << 45)) >> 46);
        if (r > 18'd16384)
            r = 18'd16384;
        return v[63] ? -$signed(16'(r)) : $signed(16'(r));
    endfunction

    // pairs: 0 cp*cy, 1 sp*sy, 2 cp*sy, 3 sp*cy
    logic signed [41:0] pr1_reg [0:3];
    e2q_trig_t          sr1_reg, cr1_reg;
    logic signed [42:0] hs2_reg [0:3], hc2_reg [0:3];
    logic signed [43:0] ls2_reg [0:3], lc2_reg [0:3];
    logic signed [63:0] fs3_reg [0:3], fc3_reg [0:3];
    logic signed [63:0] x4_reg, y4_reg, z4_reg, w4_reg;
    e2q_out_t           out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr1_reg[0] <= 42'(cp * cy);
            pr1_reg[1] <= 42'(sp * sy);
            pr1_reg[2] <= 42'(cp * sy);
            pr1_reg[3] <= 42'(sp * cy);
            sr1_reg    <= sr;
            cr1_reg    <= cr;
            for (int i = 0; i < 4; i++)
            begin
                hs2_reg[i] <= 43'(sr1_reg * $signed(pr1_reg[i][41:21]));
                hc2_reg[i] <= 43'(cr1_reg * $signed(pr1_reg[i][41:21]));
                ls2_reg[i] <= 44'(sr1_reg * $signed({1'b0, pr1_reg[i][20:0]}));
                lc2_reg[i] <= 44'(cr1_reg * $signed({1'b0, pr1_reg[i][20:0]}));
                fs3_reg[i] <= (64'(hs2_reg[i]) <<< 21) + 64'(ls2_reg[i]);
                fc3_reg[i] <= (64'(hc2_reg[i]) <<< 21) + 64'(lc2_reg[i]);
            end
            x4_reg <= fs3_reg[0] - fc3_reg[1];
            y4_reg <= fc3_reg[3] + fs3_reg[2];
            z4_reg <= fc3_reg[2] - fs3_reg[3];
            w4_reg <= fc3_reg[0] + fs3_reg[1];
            out_reg.quat_x <= to_q14(x4_reg);
            out_reg.quat_y <= to_q14(y4_reg);
            out_reg.quat_z <= to_q14(z4_reg);
            out_reg.quat_w <= to_q14(w4_reg);
        end
    end

    assign quat = out_reg;

endmodule
`default_nettype wire
